// ----- sv/bdeq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdeq_pkg
// shared types and constants for the bounded double-ended queue
// ----------------------------------------------------------------------------
package bdeq_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned OP_W   = 3;

    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;
    localparam logic [CNT_W-1:0]  CAP_RESET  = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_REAR  = 3'd3,
        OP_NONE      = 3'd4
    } op_t;

    typedef struct packed {
        logic              ins_front;
        logic              ins_rear;
        logic              del_front;
        logic              del_rear;
        logic [WORD_W-1:0] word;
    } cell_cmd_t;

endpackage

// ----- sv/bounded_double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// deque of signed 32-bit words held in a chain of shifting cells
// ----------------------------------------------------------------------------
// Each input transfer carries an operation in s_tuser and a word in s_tdata
// and yields one result transfer with the status, front and rear words (-1
// when empty), the empty and full flags and the occupancy. The cell chain
// updates at the accepting edge; once the result register is free, it then
// loads the front word from the head cell and the rear word from the last
// occupied cell. A result waiting on m_tready lets one more input transfer
// in and then holds s_tready low until the result register is free again,
// so no new item is taken before the last one's result is loaded. The fill is
// limited to the smaller of the capacity register and DEPTH; the capacity
// register is written through cfg_wr_en and cfg_wr_data.
module bounded_double_ended_queue
    import bdeq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok[0], front_value[32:1], rear_value[64:33], is_empty[65], is_full[66],
    // occupancy[71:67]
    output logic [71:0] m_tdata
);

    localparam int unsigned EFF_MAX = (DEPTH < 31) ? DEPTH : 31;

    logic [CNT_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic              pend_reg;
    logic              pend_ok_reg;
    logic              m_tvalid_reg;
    logic [71:0]       m_tdata_reg;

    logic [CNT_W-1:0]  eff_cap;
    logic              s_xfer;
    logic              room;
    logic              ok;
    op_t               op;
    cell_cmd_t         cmd;

    logic [WORD_W-1:0] cell_data  [DEPTH];
    logic [DEPTH-1:0]  cell_valid;
    logic [DEPTH-1:0]  cell_rear;
    logic [WORD_W-1:0] rear_word;
    logic              load_out;

    assign eff_cap  = (cap_reg > CNT_W'(EFF_MAX)) ? CNT_W'(EFF_MAX) : cap_reg;
    assign s_tready = !pend_reg;
    assign s_xfer   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);
    assign room     = fill_reg < eff_cap;

    always_comb begin
        cmd       = '0;
        cmd.word  = s_tdata;
        ok        = 1'b0;
        fill_next = fill_reg;
        unique case (op)
            OP_INS_FRONT: begin
                ok            = room;
                cmd.ins_front = s_xfer && room;
            end
            OP_INS_REAR: begin
                ok           = room;
                cmd.ins_rear = s_xfer && room;
            end
            OP_DEL_FRONT: begin
                ok            = fill_reg != '0;
                cmd.del_front = s_xfer && ok;
            end
            OP_DEL_REAR: begin
                ok           = fill_reg != '0;
                cmd.del_rear = s_xfer && ok;
            end
            OP_NONE: begin
                ok = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        if (cmd.ins_front || cmd.ins_rear) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (cmd.del_front || cmd.del_rear) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] l_data;
        logic              l_valid;
        logic [WORD_W-1:0] r_data;
        logic              r_valid;

        if (i == 0) begin : g_head
            assign l_data  = s_tdata;
            assign l_valid = 1'b1;
        end else begin : g_mid
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign r_data  = '0;
            assign r_valid = 1'b0;
        end else begin : g_body
            assign r_data  = cell_data[i+1];
            assign r_valid = cell_valid[i+1];
        end

        bdeq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data_q      (cell_data[i]),
            .valid_q     (cell_valid[i]),
            .is_rear     (cell_rear[i])
        );
    end

    always_comb begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rear_word = rear_word | (cell_data[i] & {WORD_W{cell_rear[i]}});
        end
    end

    assign load_out = pend_reg && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= CAP_RESET;
            fill_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            fill_reg <= fill_next;
            if (s_xfer) begin
                pend_reg <= 1'b1;
            end else if (load_out) begin
                pend_reg <= 1'b0;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (s_xfer) begin
            pend_ok_reg <= ok;
        end
        if (load_out) begin
            m_tdata_reg <= {fill_reg,
                            fill_reg >= eff_cap,
                            fill_reg == '0,
                            (fill_reg == '0) ? EMPTY_WORD : rear_word,
                            cell_valid[0] ? cell_data[0] : EMPTY_WORD,
                            pend_ok_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_fill_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == int'(fill_reg))
        else $error("fill count differs from occupied cells");

    a_cells_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("occupied cells not contiguous from the head");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) <= EFF_MAX)
        else $error("fill beyond depth");

    a_result_from_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(pend_reg))
        else $error("result without pending item");

    a_one_rear: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_rear))
        else $error("more than one rear cell");
`endif

endmodule

// ----- sv/bdeq_cell.sv -----
// ----------------------------------------------------------------------------
// bdeq_cell
// one storage cell of the deque chain: shifts toward either neighbor or
// takes the new word when it is the first free cell
// ----------------------------------------------------------------------------
module bdeq_cell
    import bdeq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_cmd_t         cmd,
    input  logic [WORD_W-1:0] left_data,
    input  logic              left_valid,
    input  logic [WORD_W-1:0] right_data,
    input  logic              right_valid,
    output logic [WORD_W-1:0] data_q,
    output logic              valid_q,
    output logic              is_rear
);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              valid_reg;
    logic              valid_next;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        priority if (cmd.ins_front) begin
            data_next  = left_data;
            valid_next = left_valid;
        end else if (cmd.del_front) begin
            data_next  = right_data;
            valid_next = right_valid;
        end else if (cmd.ins_rear) begin
            if (!valid_reg && left_valid) begin
                data_next  = cmd.word;
                valid_next = 1'b1;
            end
        end else if (cmd.del_rear) begin
            if (valid_reg && !right_valid) begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign data_q  = data_reg;
    assign valid_q = valid_reg;
    assign is_rear = valid_reg && !right_valid;

endmodule
